// ----- src/spfw_pkg.sv -----
package spfw_pkg;

    // input word kinds
    localparam logic [2:0] K_BEGIN  = 3'd0;
    localparam logic [2:0] K_DATA   = 3'd1;
    localparam logic [2:0] K_FINISH = 3'd2;
    localparam logic [2:0] K_FLASH  = 3'd3;
    localparam logic [2:0] K_TICK   = 3'd4;

    // result word kinds
    localparam logic [2:0] RK_IDLE     = 3'd0;
    localparam logic [2:0] RK_SPI      = 3'd1;
    localparam logic [2:0] RK_READY    = 3'd2;
    localparam logic [2:0] RK_FINISHED = 3'd3;
    localparam logic [2:0] RK_FAILED   = 3'd4;
    localparam logic [2:0] RK_REJECTED = 3'd5;

    // failure stages
    localparam logic [3:0] ST_ENABLE_STATUS  = 4'd2;
    localparam logic [3:0] ST_ERASE_STATUS   = 4'd4;
    localparam logic [3:0] ST_BLANK_CHECK    = 4'd5;
    localparam logic [3:0] ST_PROGRAM_STATUS = 4'd7;
    localparam logic [3:0] ST_VERIFY         = 4'd9;
    localparam logic [3:0] ST_IDENTIFY       = 4'd12;

    // flash opcodes
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_RDSR    = 8'h05;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_ERASE   = 8'hd8;
    localparam logic [7:0] OP_RDID    = 8'h9f;
    localparam logic [7:0] OP_RSTEN   = 8'h66;
    localparam logic [7:0] OP_RST     = 8'h99;
    localparam logic [7:0] OP_PWRUP   = 8'hab;
    localparam logic [7:0] OP_FILL    = 8'hff;

    localparam logic [7:0]  BP_MASK    = 8'h7c;
    localparam logic [7:0]  ERASED     = 8'hff;
    localparam logic [23:0] ID_ONES    = 24'hffffff;
    localparam int          PAGE_BYTES = 256;
    localparam int          PAGE_AW    = 8;
    localparam int          ERASE_CHECK_BYTES = 16;

    // config register indexes
    localparam logic [1:0] REG_TOTAL   = 2'd0;
    localparam logic [1:0] REG_ENABLE  = 2'd1;
    localparam logic [1:0] REG_ERASE   = 2'd2;
    localparam logic [1:0] REG_PROGRAM = 2'd3;

endpackage

// ----- src/spfw_ram.sv -----
module spfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/spi_flash_page_writer_unit.sv -----
// SPI NOR flash page writer.
// Input channel (in_valid/in_stall, kind, value) carries begin, host data
// bytes, finish, bytes clocked in from the flash and millisecond ticks.
// Every input word produces exactly one result word on the output channel
// (out_valid/out_stall). A result of kind SPI byte must be exchanged with the
// flash and the byte shifted in returned as a flash-byte word.
// The result of a word is registered and presented in the cycle after it is accepted.
// Throughput: one word per cycle; a new word is taken while the previous
// result waits, as long as the output register is free or being drained.
// The page buffer is a 256x8 RAM with registered read; its read address
// follows the next state so the byte needed by the following word is ready.
// When the receiver stalls, the result holds and in_stall rises, so at most
// one result is buffered.
// Reset clears the sequencer to idle, closes any session and loads the
// register defaults (length 1, timeouts 100/10000/1000 ticks).
// Registers over APB at byte addresses 0, 4, 8, 12: total length, enable,
// erase and program timeouts. Write them only while the block is idle.
module spi_flash_page_writer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  spi_byte,
    output logic        end_of_frame,
    output logic [23:0] jedec_id,
    output logic [7:0]  flash_status,
    output logic [3:0]  fail_stage,
    output logic [23:0] fail_address,
    output logic [7:0]  expected_byte,
    output logic [7:0]  actual_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spfw_pkg::*;

    typedef enum logic [4:0] {
        P_IDLE, P_ID_RESET, P_ID_RSTEN, P_ID_RST, P_ID_WAIT1, P_ID_PWR,
        P_ID_WAIT2, P_ID_RDID, P_ID_RDSR,
        P_E_WREN, P_E_WEL, P_E_CMD, P_E_BUSY, P_E_READ,
        P_W_WREN, P_W_WEL, P_W_CMD, P_W_BUSY, P_W_READ
    } phase_t;

    function automatic logic is_poll(phase_t p);
        return p == P_E_WEL || p == P_E_BUSY || p == P_W_WEL || p == P_W_BUSY;
    endfunction

    function automatic logic [8:0] frame_len(phase_t p, logic [8:0] fill);
        case (p)
            P_ID_RESET:          return 9'd9;
            P_ID_RDID:           return 9'd4;
            P_ID_RDSR:           return 9'd2;
            P_E_CMD:             return 9'd4;
            P_E_READ:            return 9'(4 + ERASE_CHECK_BYTES);
            P_W_CMD, P_W_READ:   return 9'd4 + fill;
            P_ID_RSTEN, P_ID_RST, P_ID_PWR, P_E_WREN, P_W_WREN: return 9'd1;
            P_E_WEL, P_E_BUSY, P_W_WEL, P_W_BUSY: return 9'd2;
            default:             return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(phase_t p, logic [8:0] i,
                                              logic [24:0] wa, logic [7:0] pb);
        logic [7:0] cmd;
        cmd = OP_RDSR;
        case (p)
            P_ID_RESET:          return OP_FILL;
            P_ID_RSTEN:          return OP_RSTEN;
            P_ID_RST:            return OP_RST;
            P_ID_PWR:            return OP_PWRUP;
            P_ID_RDID:           return (i == 9'd0) ? OP_RDID : 8'h00;
            P_E_WREN, P_W_WREN:  return OP_WREN;
            P_E_CMD:             cmd = OP_ERASE;
            P_W_CMD:             cmd = OP_PROGRAM;
            P_E_READ, P_W_READ:  cmd = OP_READ;
            default:             return (i == 9'd0) ? OP_RDSR : 8'h00;
        endcase
        if (i == 9'd0)
        begin
            return cmd;
        end
        case (i)
            9'd1:    return wa[23:16];
            9'd2:    return wa[15:8];
            9'd3:    return wa[7:0];
            default: return (p == P_W_CMD) ? pb : 8'h00;
        endcase
    endfunction

    // configuration
    logic [24:0] total_length_reg;
    logic [15:0] enable_timeout_reg;
    logic [15:0] erase_timeout_reg;
    logic [15:0] program_timeout_reg;
    logic        cfg_write;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [8:0]  fill_reg, fill_next;
    logic [24:0] waddr_reg, waddr_next;
    logic        session_reg, session_next;
    logic [8:0]  findex_reg, findex_next;
    logic [15:0] deadline_reg, deadline_next;
    logic [7:0]  status_reg, status_next;
    logic [23:0] id_reg, id_next;
    logic        finishing_reg, finishing_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  rkind_reg, rkind_next;
    logic [7:0]  spi_reg, spi_next;
    logic        eof_reg, eof_next;
    logic [23:0] jedec_reg;
    logic [7:0]  fstatus_reg;
    logic [3:0]  stage_reg, stage_next;
    logic [23:0] faddr_reg, faddr_next;
    logic [7:0]  exp_reg, exp_next;
    logic [7:0]  act_reg, act_next;

    // step control
    logic        in_accept;
    logic        do_emit, do_enter, do_fail, do_flush_done;
    phase_t      enter_phase;
    logic [8:0]  cur_len;
    logic [15:0] dl_dec;
    logic [32:0] capacity;
    logic [24:0] sum_addr;
    logic [25:0] fill_end;
    logic        mem_we;
    logic [PAGE_AW-1:0] mem_raddr;
    logic [7:0]  mem_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_TOTAL:   prdata = {7'd0, total_length_reg};
            REG_ENABLE:  prdata = {16'd0, enable_timeout_reg};
            REG_ERASE:   prdata = {16'd0, erase_timeout_reg};
            REG_PROGRAM: prdata = {16'd0, program_timeout_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg    <= 25'd1;
            enable_timeout_reg  <= 16'd100;
            erase_timeout_reg   <= 16'd10000;
            program_timeout_reg <= 16'd1000;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TOTAL:   total_length_reg    <= pwdata[24:0];
                REG_ENABLE:  enable_timeout_reg  <= pwdata[15:0];
                REG_ERASE:   erase_timeout_reg   <= pwdata[15:0];
                REG_PROGRAM: program_timeout_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // Take a word whenever the result register is empty or being drained.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign cur_len  = frame_len(phase_reg, fill_reg);
    assign dl_dec   = (deadline_reg != 16'd0) ? deadline_reg - 16'd1 : 16'd0;
    assign fill_end = {1'b0, waddr_reg} + 26'(fill_reg);
    // verify and blank-check addresses: write address plus byte offset
    assign sum_addr = waddr_reg + 25'(findex_reg) - 25'd4;

    always_comb
    begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        waddr_next     = waddr_reg;
        session_next   = session_reg;
        findex_next    = findex_reg;
        deadline_next  = deadline_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        finishing_next = finishing_reg;
        rkind_next     = RK_IDLE;
        spi_next       = 8'h00;
        eof_next       = 1'b0;
        stage_next     = 4'd0;
        faddr_next     = 24'd0;
        exp_next       = 8'h00;
        act_next       = 8'h00;
        do_emit        = 1'b0;
        do_enter       = 1'b0;
        do_fail        = 1'b0;
        do_flush_done  = 1'b0;
        enter_phase    = P_IDLE;
        mem_we         = 1'b0;
        capacity       = 33'd0;

        case (kind)
            K_BEGIN:
            begin
                if (session_reg || phase_reg != P_IDLE || total_length_reg == 25'd0
                    || total_length_reg > 25'h1000000)
                begin
                    rkind_next = RK_REJECTED;
                end
                else
                begin
                    id_next        = 24'd0;
                    status_next    = 8'h00;
                    finishing_next = 1'b0;
                    do_enter       = 1'b1;
                    enter_phase    = P_ID_RESET;
                end
            end
            K_DATA:
            begin
                if (!session_reg || phase_reg != P_IDLE || fill_reg >= 9'(PAGE_BYTES)
                    || fill_end + 26'd1 > {1'b0, total_length_reg})
                begin
                    rkind_next = RK_REJECTED;
                end
                else
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + 9'd1;
                    if (fill_next == 9'(PAGE_BYTES))
                    begin
                        do_enter    = 1'b1;
                        enter_phase = (waddr_reg[15:0] == 16'd0) ? P_E_WREN : P_W_WREN;
                    end
                end
            end
            K_FINISH:
            begin
                if (!session_reg || phase_reg != P_IDLE
                    || fill_end != {1'b0, total_length_reg})
                begin
                    rkind_next = RK_REJECTED;
                end
                else
                begin
                    finishing_next = 1'b1;
                    if (fill_reg == 9'd0)
                    begin
                        do_flush_done = 1'b1;
                    end
                    else
                    begin
                        do_enter    = 1'b1;
                        enter_phase = (waddr_reg[15:0] == 16'd0) ? P_E_WREN : P_W_WREN;
                    end
                end
            end
            K_FLASH:
            begin
                if (cur_len == 9'd0 || findex_reg >= cur_len)
                begin
                    rkind_next = RK_REJECTED;
                end
                else
                begin
                    if (phase_reg == P_ID_RDID && findex_reg >= 9'd1)
                    begin
                        id_next = {id_reg[15:0], value};
                    end
                    else if ((phase_reg == P_ID_RDSR || is_poll(phase_reg))
                             && findex_reg == 9'd1)
                    begin
                        status_next = value;
                    end
                    else if (phase_reg == P_E_READ && findex_reg >= 9'd4 && value != ERASED)
                    begin
                        do_fail    = 1'b1;
                        stage_next = ST_BLANK_CHECK;
                        faddr_next = sum_addr[23:0];
                        exp_next   = ERASED;
                        act_next   = value;
                    end
                    else if (phase_reg == P_W_READ && findex_reg >= 9'd4
                             && value != mem_rdata)
                    begin
                        do_fail    = 1'b1;
                        stage_next = ST_VERIFY;
                        faddr_next = sum_addr[23:0];
                        exp_next   = mem_rdata;
                        act_next   = value;
                    end

                    if (!do_fail)
                    begin
                        findex_next = findex_reg + 9'd1;
                        if (findex_next < cur_len)
                        begin
                            do_emit = 1'b1;
                        end
                        else
                        begin
                            // frame complete: advance the sequence
                            do_enter = 1'b1;
                            case (phase_reg)
                                P_ID_RESET: enter_phase = P_ID_RSTEN;
                                P_ID_RSTEN: enter_phase = P_ID_RST;
                                P_ID_RST:   enter_phase = P_ID_WAIT1;
                                P_ID_PWR:   enter_phase = P_ID_WAIT2;
                                P_ID_RDID:  enter_phase = P_ID_RDSR;
                                P_E_WREN:   enter_phase = P_E_WEL;
                                P_W_WREN:   enter_phase = P_W_WEL;
                                P_E_CMD:    enter_phase = P_E_BUSY;
                                P_E_READ:   enter_phase = P_W_WREN;
                                P_W_CMD:    enter_phase = P_W_BUSY;
                                P_W_READ:
                                begin
                                    do_enter      = 1'b0;
                                    do_flush_done = 1'b1;
                                end
                                P_ID_RDSR:
                                begin
                                    do_enter    = 1'b0;
                                    findex_next = 9'd0;
                                    if (id_next == 24'd0 || id_next == ID_ONES)
                                    begin
                                        do_fail    = 1'b1;
                                        stage_next = ST_IDENTIFY;
                                        act_next   = status_next;
                                    end
                                    else
                                    begin
                                        phase_next = P_IDLE;
                                        capacity   = 33'd1 << id_next[4:0];
                                        if (id_next[7:5] != 3'd0
                                            || {8'd0, total_length_reg} > capacity
                                            || (status_next & BP_MASK) != 8'h00)
                                        begin
                                            rkind_next = RK_REJECTED;
                                        end
                                        else
                                        begin
                                            session_next   = 1'b1;
                                            waddr_next     = 25'd0;
                                            fill_next      = 9'd0;
                                            finishing_next = 1'b0;
                                            rkind_next     = RK_READY;
                                        end
                                    end
                                end
                                default:
                                begin
                                    // status poll: check WEL set or WIP/WEL clear
                                    if ((phase_reg == P_E_WEL || phase_reg == P_W_WEL)
                                        ? status_next[1] : status_next[1:0] == 2'b00)
                                    begin
                                        case (phase_reg)
                                            P_E_WEL:  enter_phase = P_E_CMD;
                                            P_E_BUSY: enter_phase = P_E_READ;
                                            P_W_WEL:  enter_phase = P_W_CMD;
                                            default:  enter_phase = P_W_READ;
                                        endcase
                                    end
                                    else
                                    begin
                                        do_enter    = 1'b0;
                                        findex_next = 9'd2;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            K_TICK:
            begin
                if (phase_reg == P_ID_WAIT1)
                begin
                    do_enter    = 1'b1;
                    enter_phase = P_ID_PWR;
                end
                else if (phase_reg == P_ID_WAIT2)
                begin
                    do_enter    = 1'b1;
                    enter_phase = P_ID_RDID;
                end
                else if (is_poll(phase_reg) && findex_reg == 9'd2)
                begin
                    deadline_next = dl_dec;
                    if (dl_dec == 16'd0)
                    begin
                        do_fail    = 1'b1;
                        faddr_next = waddr_reg[23:0];
                        act_next   = status_reg;
                        case (phase_reg)
                            P_E_WEL, P_W_WEL:
                            begin
                                stage_next = ST_ENABLE_STATUS;
                                exp_next   = 8'h02;
                            end
                            P_E_BUSY: stage_next = ST_ERASE_STATUS;
                            default:  stage_next = ST_PROGRAM_STATUS;
                        endcase
                    end
                    else
                    begin
                        findex_next = 9'd0;
                        do_emit     = 1'b1;
                    end
                end
            end
            default:
            begin
                rkind_next = RK_REJECTED;
            end
        endcase

        if (do_flush_done)
        begin
            waddr_next  = waddr_reg + 25'(fill_reg);
            fill_next   = 9'd0;
            phase_next  = P_IDLE;
            findex_next = 9'd0;
            if (finishing_next)
            begin
                finishing_next = 1'b0;
                session_next   = 1'b0;
                rkind_next     = RK_FINISHED;
            end
        end

        if (do_fail)
        begin
            phase_next     = P_IDLE;
            findex_next    = 9'd0;
            session_next   = 1'b0;
            finishing_next = 1'b0;
            fill_next      = 9'd0;
            rkind_next     = RK_FAILED;
        end

        if (do_enter)
        begin
            phase_next  = enter_phase;
            findex_next = 9'd0;
            case (enter_phase)
                P_E_WEL, P_W_WEL: deadline_next = enable_timeout_reg;
                P_E_BUSY:         deadline_next = erase_timeout_reg;
                P_W_BUSY:         deadline_next = program_timeout_reg;
                default:          ;
            endcase
            if (is_poll(enter_phase) && deadline_next == 16'd0)
            begin
                deadline_next = 16'd1;
            end
            if (enter_phase != P_ID_WAIT1 && enter_phase != P_ID_WAIT2)
            begin
                do_emit = 1'b1;
            end
        end

        if (do_emit)
        begin
            rkind_next = RK_SPI;
            spi_next   = frame_byte(phase_next, findex_next, waddr_next, mem_rdata);
            eof_next   = (findex_next + 9'd1) >= frame_len(phase_next, fill_next);
        end
    end

    // Prefetch the page byte the next word needs: program sends entry
    // index-3 after this byte, verify compares entry index-4.
    assign mem_raddr = (phase_next == P_W_CMD) ? findex_next[PAGE_AW-1:0] - 8'd3
                                               : findex_next[PAGE_AW-1:0] - 8'd4;

    spfw_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page (
        .clk   (clk),
        .we    (in_accept && mem_we),
        .waddr (fill_reg[PAGE_AW-1:0]),
        .wdata (value),
        .raddr (in_accept ? mem_raddr
                          : ((phase_reg == P_W_CMD) ? findex_reg[PAGE_AW-1:0] - 8'd3
                                                    : findex_reg[PAGE_AW-1:0] - 8'd4)),
        .rdata (mem_rdata)
    );

    assign out_valid_next = in_accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            fill_reg      <= 9'd0;
            waddr_reg     <= 25'd0;
            session_reg   <= 1'b0;
            findex_reg    <= 9'd0;
            deadline_reg  <= 16'd0;
            status_reg    <= 8'h00;
            id_reg        <= 24'd0;
            finishing_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg     <= phase_next;
                fill_reg      <= fill_next;
                waddr_reg     <= waddr_next;
                session_reg   <= session_next;
                findex_reg    <= findex_next;
                deadline_reg  <= deadline_next;
                status_reg    <= status_next;
                id_reg        <= id_next;
                finishing_reg <= finishing_next;
            end
        end
    end

    // result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rkind_reg   <= rkind_next;
            spi_reg     <= spi_next;
            eof_reg     <= eof_next;
            jedec_reg   <= id_next;
            fstatus_reg <= status_next;
            stage_reg   <= stage_next;
            faddr_reg   <= faddr_next;
            exp_reg     <= exp_next;
            act_reg     <= act_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = rkind_reg;
    assign spi_byte      = spi_reg;
    assign end_of_frame  = eof_reg;
    assign jedec_id      = jedec_reg;
    assign flash_status  = fstatus_reg;
    assign fail_stage    = stage_reg;
    assign fail_address  = faddr_reg;
    assign expected_byte = exp_reg;
    assign actual_byte   = act_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 9'(PAGE_BYTES))
        else $error("page fill count past page size");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == P_IDLE |-> findex_reg == 9'd0)
        else $error("frame index left nonzero in idle");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_fail_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && do_fail |=> phase_reg == P_IDLE && !session_reg
                                 && fill_reg == 9'd0)
        else $error("failure did not close the session");

    a_spi_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rkind_reg != RK_SPI |-> spi_reg == 8'h00 && !eof_reg)
        else $error("spi byte shown on non-spi result");

endmodule

// ----- tb/spi_flash_page_writer_unit_test.sv -----
module spi_flash_page_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spfw_pkg::*;

    // status register bits polled by the sequencer
    localparam logic [7:0] WEL_BIT   = 8'h02;
    localparam logic [7:0] BUSY_BITS = 8'h03;

    // sequencer phases, in the order the block walks through them
    typedef enum logic [4:0] {
        P_IDLE, P_ID_RESET, P_ID_RSTEN, P_ID_RST, P_ID_WAIT1, P_ID_PWR,
        P_ID_WAIT2, P_ID_RDID, P_ID_RDSR,
        P_E_WREN, P_E_WEL, P_E_CMD, P_E_BUSY, P_E_READ,
        P_W_WREN, P_W_WEL, P_W_CMD, P_W_BUSY, P_W_READ
    } seq_phase_t;

    // flash misbehavior injected into one flush
    typedef enum int {F_NONE, F_BLANK, F_VERIFY, F_TO_WEL, F_TO_BUSY} flash_fault_t;

    typedef struct packed {
        logic [2:0]  rk;
        logic [7:0]  spi;
        logic        eof;
        logic [23:0] id;
        logic [7:0]  st;
        logic [3:0]  stage;
        logic [23:0] addr;
        logic [7:0]  exp_b;
        logic [7:0]  act_b;
    } result_t;

    // Page writer predictor plus the queue of results still owed by the block.
    class flash_writer_scoreboard;
        bit [24:0]    total_len = 25'd1;
        bit [15:0]    en_ticks = 16'd100;
        bit [15:0]    er_ticks = 16'd10000;
        bit [15:0]    pg_ticks = 16'd1000;
        bit [7:0]     page [PAGE_BYTES];
        int unsigned  fill;
        int unsigned  fidx;
        int unsigned  deadline;
        bit [24:0]    waddr;
        bit           active;
        bit           finishing;
        seq_phase_t   phase = P_IDLE;
        bit [7:0]     status;
        bit [23:0]    id;
        result_t      owed [$];
        int           errors;

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_TOTAL:   total_len = data[24:0];
                REG_ENABLE:  en_ticks = data[15:0];
                REG_ERASE:   er_ticks = data[15:0];
                REG_PROGRAM: pg_ticks = data[15:0];
                default: ;
            endcase
        endfunction

        function result_t word_out(logic [2:0] rk, logic [7:0] spi = 0, logic eof = 0,
                                   logic [3:0] stage = 0, logic [23:0] addr = 0,
                                   logic [7:0] ex = 0, logic [7:0] ac = 0);
            result_t r;
            r.rk = rk;
            r.spi = spi;
            r.eof = eof;
            r.id = id;
            r.st = status;
            r.stage = stage;
            r.addr = addr;
            r.exp_b = ex;
            r.act_b = ac;
            return r;
        endfunction

        function bit polling(seq_phase_t p);
            return p == P_E_WEL || p == P_E_BUSY || p == P_W_WEL || p == P_W_BUSY;
        endfunction

        function int unsigned frame_len();
            case (phase)
                P_ID_RESET: return 9;
                P_ID_RDID:  return 4;
                P_ID_RDSR:  return 2;
                P_E_CMD:    return 4;
                P_E_READ:   return 4 + ERASE_CHECK_BYTES;
                P_W_CMD, P_W_READ: return 4 + fill;
                P_ID_RSTEN, P_ID_RST, P_ID_PWR, P_E_WREN, P_W_WREN: return 1;
                default: return polling(phase) ? 2 : 0;
            endcase
        endfunction

        function logic [7:0] frame_byte(int unsigned i);
            logic [23:0] a;
            logic [7:0]  cmd;
            a = waddr[23:0];
            case (phase)
                P_ID_RESET: return OP_FILL;
                P_ID_RSTEN: return OP_RSTEN;
                P_ID_RST:   return OP_RST;
                P_ID_PWR:   return OP_PWRUP;
                P_ID_RDID:  return i == 0 ? OP_RDID : 8'h00;
                P_E_WREN, P_W_WREN: return OP_WREN;
                P_E_CMD:    cmd = OP_ERASE;
                P_W_CMD:    cmd = OP_PROGRAM;
                P_E_READ, P_W_READ: cmd = OP_READ;
                default:    return i == 0 ? OP_RDSR : 8'h00;
            endcase
            if (i == 0) return cmd;
            if (i < 4) return 8'(a >> (8 * (3 - i)));
            if (phase == P_W_CMD && i - 4 < PAGE_BYTES) return page[i - 4];
            return 8'h00;
        endfunction

        function result_t spi_out();
            return word_out(RK_SPI, frame_byte(fidx), fidx + 1 >= frame_len());
        endfunction

        function result_t enter(seq_phase_t p);
            int unsigned t;
            phase = p;
            fidx = 0;
            if (polling(p)) begin
                t = (p == P_E_WEL || p == P_W_WEL) ? en_ticks :
                    (p == P_E_BUSY) ? er_ticks : pg_ticks;
                deadline = (t != 0) ? t : 1;
            end
            if (p == P_ID_WAIT1 || p == P_ID_WAIT2) return word_out(RK_IDLE);
            return spi_out();
        endfunction

        function result_t fail(logic [3:0] stage, logic [23:0] addr,
                               logic [7:0] ex, logic [7:0] ac);
            phase = P_IDLE;
            fidx = 0;
            active = 0;
            finishing = 0;
            fill = 0;
            return word_out(RK_FAILED, 0, 0, stage, addr, ex, ac);
        endfunction

        function result_t identify_end();
            logic [63:0] cap;
            cap = (id[7:0] < 32) ? (64'd1 << id[7:0]) : 64'd0;
            if (id == 24'd0 || id == ID_ONES) return fail(ST_IDENTIFY, 0, 0, status);
            phase = P_IDLE;
            fidx = 0;
            if (cap == 0 || 64'(total_len) > cap || (status & BP_MASK) != 0)
                return word_out(RK_REJECTED);
            active = 1;
            waddr = 0;
            fill = 0;
            finishing = 0;
            return word_out(RK_READY);
        endfunction

        function result_t flush_done();
            waddr = waddr + 25'(fill);
            fill = 0;
            phase = P_IDLE;
            fidx = 0;
            if (finishing) begin
                finishing = 0;
                active = 0;
                return word_out(RK_FINISHED);
            end
            return word_out(RK_IDLE);
        endfunction

        function result_t start_flush();
            return enter(waddr[15:0] == 0 ? P_E_WREN : P_W_WREN);
        endfunction

        function result_t frame_done();
            logic [7:0] mask;
            logic [7:0] want;
            seq_phase_t nxt;
            case (phase)
                P_ID_RESET: return enter(P_ID_RSTEN);
                P_ID_RSTEN: return enter(P_ID_RST);
                P_ID_RST:   return enter(P_ID_WAIT1);
                P_ID_PWR:   return enter(P_ID_WAIT2);
                P_ID_RDID:  return enter(P_ID_RDSR);
                P_ID_RDSR:  return identify_end();
                P_E_WREN:   return enter(P_E_WEL);
                P_W_WREN:   return enter(P_W_WEL);
                P_E_CMD:    return enter(P_E_BUSY);
                P_E_READ:   return enter(P_W_WREN);
                P_W_CMD:    return enter(P_W_BUSY);
                P_W_READ:   return flush_done();
                default: ;
            endcase
            if (phase == P_E_WEL || phase == P_W_WEL) begin
                mask = WEL_BIT;
                want = WEL_BIT;
            end else begin
                mask = BUSY_BITS;
                want = 8'h00;
            end
            nxt = phase == P_E_WEL ? P_E_CMD : phase == P_E_BUSY ? P_E_READ :
                  phase == P_W_WEL ? P_W_CMD : P_W_READ;
            if ((status & mask) == want) return enter(nxt);
            fidx = 2;
            return word_out(RK_IDLE);
        endfunction

        function result_t flash_byte(logic [7:0] r);
            int unsigned len;
            int unsigned i;
            len = frame_len();
            i = fidx;
            if (len == 0 || i >= len) return word_out(RK_REJECTED);
            if (phase == P_ID_RDID && i >= 1)
                id = {id[15:0], r};
            else if ((phase == P_ID_RDSR || polling(phase)) && i == 1)
                status = r;
            else if (phase == P_E_READ && i >= 4 && r != ERASED)
                return fail(ST_BLANK_CHECK, 24'(waddr + i - 4), ERASED, r);
            else if (phase == P_W_READ && i >= 4 && r != page[i - 4])
                return fail(ST_VERIFY, 24'(waddr + i - 4), page[i - 4], r);
            fidx = i + 1;
            if (fidx < len) return spi_out();
            return frame_done();
        endfunction

        function result_t tick();
            bit wel;
            if (phase == P_ID_WAIT1) return enter(P_ID_PWR);
            if (phase == P_ID_WAIT2) return enter(P_ID_RDID);
            if (polling(phase) && fidx == 2) begin
                if (deadline > 0) deadline--;
                if (deadline == 0) begin
                    wel = phase == P_E_WEL || phase == P_W_WEL;
                    return fail(wel ? ST_ENABLE_STATUS :
                                phase == P_E_BUSY ? ST_ERASE_STATUS : ST_PROGRAM_STATUS,
                                waddr[23:0], wel ? WEL_BIT : 8'h00, status);
                end
                fidx = 0;
                return spi_out();
            end
            return word_out(RK_IDLE);
        endfunction

        function result_t predict(logic [2:0] k, logic [7:0] v);
            bit busy;
            busy = phase != P_IDLE;
            case (k)
                K_BEGIN: begin
                    if (active || busy || total_len == 0 || total_len > 25'h1000000)
                        return word_out(RK_REJECTED);
                    id = 0;
                    status = 0;
                    finishing = 0;
                    return enter(P_ID_RESET);
                end
                K_DATA: begin
                    if (!active || busy || fill >= PAGE_BYTES ||
                        int'(waddr) + fill + 1 > int'(total_len))
                        return word_out(RK_REJECTED);
                    page[fill] = v;
                    fill++;
                    if (fill == PAGE_BYTES) return start_flush();
                    return word_out(RK_IDLE);
                end
                K_FINISH: begin
                    if (!active || busy || int'(waddr) + fill != int'(total_len))
                        return word_out(RK_REJECTED);
                    finishing = 1;
                    if (fill == 0) return flush_done();
                    return start_flush();
                end
                K_FLASH: return flash_byte(v);
                K_TICK:  return tick();
                default: return word_out(RK_REJECTED);
            endcase
        endfunction

        function void note_word(logic [2:0] k, logic [7:0] v);
            owed.push_back(predict(k, v));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result word with nothing expected: kind %0d", $realtime,
                             got.rk);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch kind %0d/%0d spi %h/%h eof %b/%b id %h/%h",
                             $realtime, want.rk, got.rk, want.spi, got.spi, want.eof,
                             got.eof, want.id, got.id);
                    $display("    status %h/%h stage %0d/%0d addr %h/%h exp %h/%h act %h/%h",
                             want.st, got.st, want.stage, got.stage, want.addr, got.addr,
                             want.exp_b, got.exp_b, want.act_b, got.act_b);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = K_TICK;
    logic [7:0]  value = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  result_kind;
    logic [7:0]  spi_byte;
    logic        end_of_frame;
    logic [23:0] jedec_id;
    logic [7:0]  flash_status;
    logic [3:0]  fail_stage;
    logic [23:0] fail_address;
    logic [7:0]  expected_byte;
    logic [7:0]  actual_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    flash_writer_scoreboard sb = new();

    // bookkeeping for the word sender and the emulated flash part
    int           burst_left;
    int           items;
    logic [7:0]   plan_id [3];
    logic [7:0]   plan_status;
    flash_fault_t fault;
    flash_fault_t forced_fault = F_NONE;
    int unsigned  fault_pos;
    int unsigned  bad_left;
    seq_phase_t   seen_phase = P_IDLE;
    int unsigned  stall_cyc;

    spi_flash_page_writer_unit dut (.*);

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stall pattern: cycle in turn through no stall, coin flips, evenly
    // spaced stalls and short stall bursts, changing mode as the counter advances.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_cyc <= 0;
        end else begin
            stall_cyc <= stall_cyc + 1;
            case ((stall_cyc / 97) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= $urandom_range(0, 1);
                2: out_stall <= (stall_cyc % 3) == 0;
                default: out_stall <= (stall_cyc % 16) < 5;
            endcase
        end
    end

    // Check every result word the block hands over.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({result_kind, spi_byte, end_of_frame, jedec_id, flash_status,
                             fail_stage, fail_address, expected_byte, actual_byte});
    end

    // Present one input word and hold it until accepted; open a random gap
    // whenever the current burst runs out.
    task automatic send_word(input logic [2:0] k, input logic [7:0] v);
        int gap;
        gap = 0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        value <= v;
        do @(posedge clk); while (in_stall);
        sb.note_word(k, v);
        burst_left--;
        items++;
    endtask

    // Drop valid and let every owed result drain, then idle briefly as slack.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Byte the emulated flash shifts back for the exchange now in flight.
    function automatic logic [7:0] flash_reply();
        int unsigned i;
        int unsigned eff;
        bit          to_hit;
        i = sb.fidx;
        if (sb.polling(sb.phase) && sb.phase != seen_phase) begin
            eff = sb.deadline;
            to_hit = (fault == F_TO_WEL && (sb.phase == P_E_WEL || sb.phase == P_W_WEL)) ||
                     (fault == F_TO_BUSY && (sb.phase == P_E_BUSY || sb.phase == P_W_BUSY));
            bad_left = to_hit ? 32'hffff_ffff : $urandom_range(0, eff > 3 ? 3 : eff - 1);
        end
        seen_phase = sb.phase;
        case (sb.phase)
            P_ID_RDID: return i >= 1 ? plan_id[i - 1] : 8'($urandom);
            P_ID_RDSR: return i == 1 ? plan_status : 8'($urandom);
            P_E_WEL, P_W_WEL: begin
                if (i != 1) return 8'($urandom);
                if (bad_left > 0) begin
                    bad_left--;
                    return 8'($urandom) & ~WEL_BIT;
                end
                return 8'($urandom) | WEL_BIT;
            end
            P_E_BUSY, P_W_BUSY: begin
                if (i != 1) return 8'($urandom);
                if (bad_left > 0) begin
                    bad_left--;
                    return (8'($urandom) & ~BUSY_BITS) | 8'($urandom_range(1, 3));
                end
                return 8'($urandom) & ~BUSY_BITS;
            end
            P_E_READ: begin
                if (i >= 4 && fault == F_BLANK && i == fault_pos)
                    return ERASED ^ 8'($urandom_range(1, 255));
                return i >= 4 ? ERASED : 8'($urandom);
            end
            P_W_READ: begin
                if (i < 4) return 8'($urandom);
                if (fault == F_VERIFY && i == fault_pos)
                    return sb.page[i - 4] ^ 8'($urandom_range(1, 255));
                return sb.page[i - 4];
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // Play the flash side until the sequencer comes back to idle; sprinkle in
    // stray words other than flash bytes while it is busy.
    task automatic serve_flash();
        logic [2:0] nk;
        while (sb.phase != P_IDLE) begin
            if ($urandom_range(0, 29) == 0) begin
                nk = 3'($urandom_range(0, 7));
                if (nk == K_FLASH) nk = K_TICK;
                send_word(nk, 8'($urandom));
            end else if (sb.phase == P_ID_WAIT1 || sb.phase == P_ID_WAIT2 ||
                         (sb.polling(sb.phase) && sb.fidx == 2))
                send_word(K_TICK, 8'($urandom));
            else
                send_word(K_FLASH, flash_reply());
        end
    endtask

    // Choose what goes wrong in the flush the next word may start.
    task automatic pick_fault(input int pct);
        flash_fault_t cand [$];
        fault = F_NONE;
        if (forced_fault != F_NONE) begin
            fault = forced_fault;
            return;
        end
        if ($urandom_range(0, 99) >= pct) return;
        cand.push_back(F_VERIFY);
        if (sb.waddr[15:0] == 0) cand.push_back(F_BLANK);
        if (sb.en_ticks <= 8) cand.push_back(F_TO_WEL);
        if (sb.er_ticks <= 8 && sb.pg_ticks <= 8) cand.push_back(F_TO_BUSY);
        fault = cand[$urandom_range(0, cand.size() - 1)];
        fault_pos = fault == F_BLANK ? $urandom_range(4, 3 + ERASE_CHECK_BYTES) :
                    4 + $urandom_range(0, sb.fill);
    endtask

    task automatic plan_flash(input logic [7:0] code, input logic [7:0] st);
        plan_id[0] = 8'($urandom_range(1, 254));
        plan_id[1] = 8'($urandom);
        plan_id[2] = code;
        plan_status = st;
    endtask

    // One session: begin, stream the bytes, then finish. Stray finishes and
    // overrun bytes are mixed in and must be rejected.
    task automatic run_session(input int unsigned n_bytes, input int fault_pct);
        pick_fault(fault_pct);
        send_word(K_BEGIN, 8'($urandom));
        serve_flash();
        for (int unsigned b = 0; b < n_bytes && sb.active; b++) begin
            if ($urandom_range(0, 39) == 0) send_word(K_FINISH, 8'($urandom));
            pick_fault(fault_pct);
            send_word(K_DATA, 8'($urandom));
            serve_flash();
        end
        if (!sb.active) return;
        if ($urandom_range(0, 3) == 0) send_word(K_DATA, 8'($urandom));
        pick_fault(fault_pct);
        send_word(K_FINISH, 8'($urandom));
        serve_flash();
    endtask

    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3: return 16'($urandom);
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    initial begin
        logic [24:0] len;
        logic [7:0]  code;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // words that make no sense with no session open
        send_word(K_TICK, 8'h00);
        send_word(K_FLASH, 8'hff);
        send_word(K_DATA, 8'h5a);
        send_word(K_FINISH, 8'ha5);
        for (int k = K_TICK + 1; k < 8; k++) send_word(3'(k), 8'($urandom));

        // lengths the begin must refuse
        write_reg(REG_TOTAL, 32'd0);
        send_word(K_BEGIN, 8'h00);
        write_reg(REG_TOTAL, 32'h1ff_ffff);
        send_word(K_BEGIN, 8'hff);
        write_reg(REG_TOTAL, 32'h100_0001);
        send_word(K_BEGIN, 8'h00);

        // identify outcomes: blank IDs fail, small or odd capacity and
        // protected blocks are refused
        write_reg(REG_TOTAL, 32'd16);
        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_ERASE, 32'd0);
        write_reg(REG_PROGRAM, 32'd0);
        plan_id = '{8'h00, 8'h00, 8'h00};
        plan_status = 8'h00;
        run_session(16, 0);
        plan_id = '{8'hff, 8'hff, 8'hff};
        run_session(16, 0);
        plan_flash(8'd40, 8'h00);
        run_session(16, 0);
        plan_flash(8'd3, 8'h00);
        run_session(16, 0);
        plan_flash(8'd20, BP_MASK);
        run_session(16, 0);
        // capacity exactly the session length, zero tick budgets
        plan_flash(8'd4, 8'h83);
        run_session(16, 0);

        // random sessions of small size
        items = 0;
        while (items < 650) begin
            if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(0, 19) == 0 ? 25'd0 : 25'($urandom_range(1, 40));
                write_reg(REG_TOTAL, 32'(len));
            end
            if ($urandom_range(0, 2) == 0) write_reg(REG_ENABLE, 32'(pick_ticks()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_ERASE, 32'(pick_ticks()));
            if ($urandom_range(0, 2) == 0) write_reg(REG_PROGRAM, 32'(pick_ticks()));
            code = 8'($clog2(sb.total_len > 0 ? sb.total_len : 1) + $urandom_range(0, 4));
            case ($urandom_range(0, 19))
                0: code = 8'($urandom);
                1: code = 8'($urandom_range(0, 4));
                default: ;
            endcase
            plan_flash(code, $urandom_range(0, 9) == 0 ? 8'($urandom) :
                             8'($urandom) & ~BP_MASK);
            if ($urandom_range(0, 24) == 0) plan_id = '{8'h00, 8'h00, 8'h00};
            if ($urandom_range(0, 24) == 0) plan_id = '{8'hff, 8'hff, 8'hff};
            run_session(sb.total_len, 25);
            wait_idle();
        end

        // one full page flushed on its own, then finish with an empty page
        write_reg(REG_TOTAL, PAGE_BYTES);
        write_reg(REG_ENABLE, 32'd3);
        write_reg(REG_ERASE, 32'd4);
        write_reg(REG_PROGRAM, 32'd2);
        plan_flash(8'd12, 8'h00);
        run_session(PAGE_BYTES, 0);

        // largest session the address space allows; close it by letting the
        // write-enable wait run out on the first flush
        write_reg(REG_TOTAL, 32'h100_0000);
        write_reg(REG_ENABLE, 32'd2);
        write_reg(REG_ERASE, 32'hffff);
        write_reg(REG_PROGRAM, 32'hffff);
        plan_flash(8'd24, 8'h00);
        forced_fault = F_TO_WEL;
        run_session(PAGE_BYTES, 100);
        forced_fault = F_NONE;

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
src/spfw_pkg.sv
src/spfw_ram.sv
src/spi_flash_page_writer_unit.sv
tb/spi_flash_page_writer_unit_test.sv
